### rtl/core/spd_pkg.sv
`timescale 1ns / 1ps

package spd_pkg;

  localparam int unsigned DEF_MAX_NODES   = 16;
  localparam int unsigned DEF_WEIGHT_BITS = 16;

  localparam int unsigned NC_W   = 5;
  localparam int unsigned VTX_W  = 4;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned DIST_W = 20;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (VTX_W + DIST_W + VTX_W + 1);

  localparam logic [NC_W-1:0] NODE_COUNT_RST = NC_W'(16);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic {
    OP_SELECT,
    OP_RELAX
  } spd_op_e;

  typedef struct packed {
    logic [DIST_W-1:0] sum;
    logic              le;
    logic              lt;
  } spd_alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEL_RD,
    ST_SEL_CHK,
    ST_SEL_END,
    ST_REL_RD,
    ST_REL_CHK,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } spd_state_e;

endpackage

### rtl/core/spd_weight_ram.sv
`timescale 1ns / 1ps

module spd_weight_ram #(
  parameter int unsigned MAX_NODES   = spd_pkg::DEF_MAX_NODES,
  parameter int unsigned WEIGHT_BITS = spd_pkg::DEF_WEIGHT_BITS,
  localparam int unsigned DEPTH      = MAX_NODES * MAX_NODES,
  localparam int unsigned ADDR_W     = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [ADDR_W-1:0]      waddr_i,
  input  logic [WEIGHT_BITS-1:0] wdata_i,
  input  logic [ADDR_W-1:0]      raddr_i,
  output logic [WEIGHT_BITS-1:0] rdata_o
);

  logic [WEIGHT_BITS-1:0] mem_q [DEPTH];
  logic [WEIGHT_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/spd_alu.sv
`timescale 1ns / 1ps

module spd_alu #(
  parameter int unsigned WEIGHT_BITS = spd_pkg::DEF_WEIGHT_BITS
) (
  input  spd_pkg::spd_op_e                op_i,
  input  logic [spd_pkg::DIST_W-1:0]      a_i,
  input  logic [WEIGHT_BITS-1:0]          b_i,
  input  logic [spd_pkg::DIST_W-1:0]      ref_i,
  output spd_pkg::spd_alu_res_t           res_o
);

  import spd_pkg::*;

  localparam int unsigned SUM_W = ((DIST_W > WEIGHT_BITS) ? DIST_W : WEIGHT_BITS) + 1;

  logic [SUM_W-1:0]  sum_raw;
  logic [DIST_W-1:0] val;

  always_comb begin
    sum_raw = SUM_W'(a_i) + SUM_W'(b_i);
    unique case (op_i)
      OP_SELECT: val = a_i;
      OP_RELAX: begin
        // path sums that would hit the unreachable code saturate just below it
        if (sum_raw >= SUM_W'(DIST_INF)) begin
          val = DIST_INF - DIST_W'(1);
        end else begin
          val = sum_raw[DIST_W-1:0];
        end
      end
      default: val = a_i;
    endcase
    res_o.sum = val;
    res_o.le  = (val <= ref_i);
    res_o.lt  = (val < ref_i);
  end

endmodule

### rtl/core/shortest_path_matrix_dijkstra.sv
`timescale 1ns / 1ps
// load transfer (tuser 0): written into the weight matrix; the block stays idle and ready
// search transfer (tuser 1): a select pass and a relax pass per vertex over n active
// vertices (ending early once the nearest open vertex is unreachable), paced by one shared
// add/compare unit and one read port per memory, then one result per vertex, in order
// reset: control state cleared, node_count set to 16; the weight matrix is not cleared
module shortest_path_matrix_dijkstra #(
  parameter int unsigned MAX_NODES   = spd_pkg::DEF_MAX_NODES,
  parameter int unsigned WEIGHT_BITS = spd_pkg::DEF_WEIGHT_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spd_pkg::NC_W-1:0]        cfg_wdata_i,
  // from_node[3:0], to_node[7:4], weight[23:8], source_node[27:24], zero[31:28]
  input  logic [spd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd[0]
  input  logic                            s_axis_tuser_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // vertex[3:0], distance[23:4], prev_vertex[27:24], reachable[28], zero[31:29]
  output logic [spd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);

  import spd_pkg::*;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_NODES * MAX_NODES);

  spd_state_e state_q, state_d;

  logic [NC_W-1:0]        node_count_q;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [VTX_W-1:0]       src_q, src_d;
  logic [NODE_W-1:0]      j_q, j_d;
  logic [NODE_W-1:0]      m_q, m_d;
  logic [CNT_W-1:0]       k_q, k_d;
  logic [DIST_W-1:0]      best_q, best_d;
  logic                   found_q, found_d;
  logic [MAX_NODES-1:0]   visited_q, visited_d;
  logic [MAX_NODES-1:0]   touched_q, touched_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;
  logic                   out_valid_q, out_valid_d;

  logic [DIST_W-1:0]      dist_mem_q [MAX_NODES];
  logic [NODE_W-1:0]      prev_mem_q [MAX_NODES];
  logic [DIST_W-1:0]      dist_rd_q;
  logic [NODE_W-1:0]      prev_rd_q;
  logic                   dist_we;
  logic [NODE_W-1:0]      dist_wa;
  logic [DIST_W-1:0]      dist_wd;
  logic [NODE_W-1:0]      prev_wd;

  logic                   in_fire;
  logic [VTX_W-1:0]       in_from;
  logic [VTX_W-1:0]       in_to;
  logic signed [WIN_W-1:0] in_weight;
  logic [VTX_W-1:0]       in_src;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [WEIGHT_BITS-1:0] w_rd;
  logic                   w_pos;

  logic [DIST_W-1:0]      d_eff;
  logic [NODE_W-1:0]      p_eff;
  logic                   j_last;
  logic                   src_ok;
  logic [NODE_W-1:0]      src_idx;

  spd_op_e                alu_op;
  logic [DIST_W-1:0]      alu_a;
  logic [DIST_W-1:0]      alu_ref;
  spd_alu_res_t           alu_res;

  assign in_from   = s_axis_tdata_i[3:0];
  assign in_to     = s_axis_tdata_i[7:4];
  assign in_weight = s_axis_tdata_i[23:8];
  assign in_src    = s_axis_tdata_i[27:24];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign ram_we    = in_fire && (s_axis_tuser_i == CMD_LOAD) &&
                     (int'(in_from) < int'(MAX_NODES)) && (int'(in_to) < int'(MAX_NODES));
  assign ram_waddr = ADDR_W'(int'(in_from) * int'(MAX_NODES) + int'(in_to));
  assign ram_wdata = WEIGHT_BITS'(in_weight);
  assign ram_raddr = ADDR_W'(int'(m_q) * int'(MAX_NODES) + int'(j_q));

  spd_weight_ram #(
    .MAX_NODES  (MAX_NODES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(w_rd)
  );

  assign w_pos = !w_rd[WEIGHT_BITS-1] && (w_rd != '0);

  // entries not written during this search read as unreachable, predecessor itself
  assign d_eff  = touched_q[j_q] ? dist_rd_q : DIST_INF;
  assign p_eff  = touched_q[j_q] ? prev_rd_q : j_q;
  assign j_last = ((CNT_W'(j_q) + CNT_W'(1)) == n_q);
  assign src_ok  = (int'(src_q) < int'(n_q));
  assign src_idx = NODE_W'(src_q);

  assign alu_op  = (state_q == ST_SEL_CHK) ? OP_SELECT : OP_RELAX;
  assign alu_a   = (state_q == ST_SEL_CHK) ? d_eff : best_q;
  assign alu_ref = (state_q == ST_SEL_CHK) ? best_q : d_eff;

  spd_alu #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (w_rd),
    .ref_i(alu_ref),
    .res_o(alu_res)
  );

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem_q[dist_wa] <= dist_wd;
      prev_mem_q[dist_wa] <= prev_wd;
    end
    dist_rd_q <= dist_mem_q[j_q];
    prev_rd_q <= prev_mem_q[j_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      src_q       <= '0;
      j_q         <= '0;
      m_q         <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      visited_q   <= '0;
      touched_q   <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      src_q       <= src_d;
      j_q         <= j_d;
      m_q         <= m_d;
      k_q         <= k_d;
      found_q     <= found_d;
      visited_q   <= visited_d;
      touched_q   <= touched_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    src_d       = src_q;
    j_d         = j_q;
    m_d         = m_q;
    k_d         = k_q;
    best_d      = best_q;
    found_d     = found_q;
    visited_d   = visited_q;
    touched_d   = touched_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    dist_we     = 1'b0;
    dist_wa     = j_q;
    dist_wd     = alu_res.sum;
    prev_wd     = m_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser_i == CMD_SEARCH)) begin
          src_d = in_src;
          if (node_count_q == '0) begin
            n_d = CNT_W'(1);
          end else if (int'(node_count_q) > int'(MAX_NODES)) begin
            n_d = CNT_W'(MAX_NODES);
          end else begin
            n_d = CNT_W'(node_count_q);
          end
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        visited_d = '0;
        touched_d = '0;
        j_d       = '0;
        k_d       = '0;
        found_d   = 1'b0;
        if (src_ok) begin
          dist_we            = 1'b1;
          dist_wa            = src_idx;
          dist_wd            = '0;
          prev_wd            = src_idx;
          touched_d[src_idx] = 1'b1;
          state_d            = ST_SEL_RD;
        end else begin
          state_d = ST_OUT_RD;
        end
      end
      ST_SEL_RD: state_d = ST_SEL_CHK;
      ST_SEL_CHK: begin
        // ties go to the higher index
        if (!visited_q[j_q] && (!found_q || alu_res.le)) begin
          best_d  = d_eff;
          m_d     = j_q;
          found_d = 1'b1;
        end
        if (j_last) begin
          state_d = ST_SEL_END;
        end else begin
          j_d     = j_q + NODE_W'(1);
          state_d = ST_SEL_RD;
        end
      end
      ST_SEL_END: begin
        visited_d[m_q] = 1'b1;
        k_d            = k_q + CNT_W'(1);
        j_d            = '0;
        found_d        = 1'b0;
        // once the nearest open vertex is unreachable nothing else changes
        state_d        = (best_q == DIST_INF) ? ST_OUT_RD : ST_REL_RD;
      end
      ST_REL_RD: state_d = ST_REL_CHK;
      ST_REL_CHK: begin
        if (!visited_q[j_q] && w_pos && alu_res.lt) begin
          dist_we        = 1'b1;
          touched_d[j_q] = 1'b1;
        end
        if (j_last) begin
          j_d     = '0;
          state_d = (k_q == n_q) ? ST_OUT_RD : ST_SEL_RD;
        end else begin
          j_d     = j_q + NODE_W'(1);
          state_d = ST_REL_RD;
        end
      end
      ST_OUT_RD: state_d = ST_OUT_LD;
      ST_OUT_LD: begin
        out_data_d  = {{OUT_PAD_W{1'b0}}, (d_eff != DIST_INF), VTX_W'(p_eff), d_eff,
                       VTX_W'(j_q)};
        out_last_d  = j_last;
        out_valid_d = 1'b1;
        state_d     = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (m_axis_tready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + NODE_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tvalid_o = out_valid_q;

endmodule

### test/spd_route_checker.sv
`timescale 1ns / 1ps

module spd_route_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spd_pkg::NC_W-1:0]        cfg_wdata_i,
  // from_node[3:0], to_node[7:4], weight[23:8], source_node[27:24], zero[31:28]
  input  logic [spd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd[0]
  input  logic                            s_axis_tuser_i,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_i,
  // vertex[3:0], distance[23:4], prev_vertex[27:24], reachable[28], zero[31:29]
  input  logic [spd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                            m_axis_tlast_i,
  input  logic                            m_axis_tvalid_i,
  input  logic                            m_axis_tready_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import spd_pkg::*;

  localparam int MAXN  = DEF_MAX_NODES;
  localparam int SUM_W = DIST_W + 1;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic [VTX_W-1:0]  prev;
    logic              reach;
    logic              last;
  } route_t;

  logic signed [WIN_W-1:0] edge_w [MAXN][MAXN];
  logic [NC_W-1:0]         vertex_cnt;
  route_t                  route_q [$];
  route_t                  want;
  route_t                  got;
  int                      bad_n = 0;

  task automatic note_fault(input string msg);
    $display("%0t: %s", $time, msg);
    bad_n++;
  endtask

  // dijkstra over the active vertices, ties go to the highest index
  function automatic void solve_routes(input logic [VTX_W-1:0] src);
    logic [DIST_W-1:0] cost [MAXN];
    logic [VTX_W-1:0]  via [MAXN];
    logic              settled [MAXN];
    logic [DIST_W-1:0] best;
    logic [SUM_W-1:0]  sum;
    logic              found;
    int                n;
    int                m;
    route_t            r;
    n = (vertex_cnt == 0) ? 1 : ((vertex_cnt > MAXN) ? MAXN : int'(vertex_cnt));
    for (int k = 0; k < MAXN; k++) begin
      cost[k]    = DIST_INF;
      via[k]     = VTX_W'(k);
      settled[k] = 1'b0;
    end
    if (src < n) begin
      cost[src] = '0;
      for (int k = 0; k < n; k++) begin
        found = 1'b0;
        best  = '0;
        m     = 0;
        for (int j = 0; j < n; j++) begin
          if (!settled[j] && (!found || cost[j] <= best)) begin
            best  = cost[j];
            m     = j;
            found = 1'b1;
          end
        end
        // unreachable vertices get settled but never relax
        if (found) begin
          settled[m] = 1'b1;
          if (cost[m] != DIST_INF) begin
            for (int j = 0; j < n; j++) begin
              if (!settled[j] && edge_w[m][j] > 0) begin
                sum = {1'b0, cost[m]} + SUM_W'(edge_w[m][j][WIN_W-2:0]);
                if (sum >= {1'b0, DIST_INF}) sum = {1'b0, DIST_INF - 1'b1};
                if (sum < {1'b0, cost[j]}) begin
                  cost[j] = sum[DIST_W-1:0];
                  via[j]  = VTX_W'(m);
                end
              end
            end
          end
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      r.vertex   = VTX_W'(k);
      r.distance = cost[k];
      r.reach    = (cost[k] != DIST_INF);
      r.prev     = r.reach ? via[k] : VTX_W'(k);
      r.last     = (k == n - 1);
      route_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_cnt = NODE_COUNT_RST;
      route_q.delete();
    end else begin
      if (cfg_we_i) vertex_cnt = cfg_wdata_i;
      // results are matched before a new search is queued
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.vertex   = m_axis_tdata_i[3:0];
        got.distance = m_axis_tdata_i[23:4];
        got.prev     = m_axis_tdata_i[27:24];
        got.reach    = m_axis_tdata_i[28];
        got.last     = m_axis_tlast_i;
        if (route_q.size() == 0) begin
          note_fault($sformatf("result transfer with nothing pending, tdata %08h",
                               m_axis_tdata_i));
        end else begin
          want = route_q.pop_front();
          if (got != want || m_axis_tdata_i[31:29] != 3'b000) begin
            note_fault($sformatf(
              "vertex %0d/%0d dist %0d/%0d prev %0d/%0d reach %0b/%0b last %0b/%0b pad %0h",
              got.vertex, want.vertex, got.distance, want.distance, got.prev, want.prev,
              got.reach, want.reach, got.last, want.last, m_axis_tdata_i[31:29]));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == CMD_LOAD) begin
          edge_w[s_axis_tdata_i[3:0]][s_axis_tdata_i[7:4]] = s_axis_tdata_i[23:8];
        end else begin
          solve_routes(s_axis_tdata_i[27:24]);
        end
      end
    end
    fail_count_o <= bad_n;
    pending_o    <= route_q.size();
  end

endmodule

### test/shortest_path_matrix_dijkstra_tb.sv
`timescale 1ns / 1ps

module shortest_path_matrix_dijkstra_tb;
  import spd_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAXN          = DEF_MAX_NODES;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [NC_W-1:0]        cfg_wdata = '0;
  logic [IN_TDATA_W-1:0]  in_data   = '0;
  logic                   in_cmd    = CMD_LOAD;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   out_last;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  int                     fail_count;
  int                     pending;
  int                     tx_idle_pct  = 8;
  int                     rx_idle_pct  = 47;
  int                     active_n     = MAXN;
  int                     stall_cycles = 0;

  always #5 clk = ~clk;

  shortest_path_matrix_dijkstra u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_cmd),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tlast_o  (out_last),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready)
  );

  spd_route_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_cmd),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_i (in_ready),
    .m_axis_tdata_i  (out_data),
    .m_axis_tlast_i  (out_last),
    .m_axis_tvalid_i (out_valid),
    .m_axis_tready_i (out_ready),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // counts cycles without any transfer on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input logic [3:0] from_v,
                           input logic [3:0] to_v, input logic [15:0] w,
                           input logic [3:0] src);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_data  <= {4'b0000, src, w, to_v, from_v};
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off the sender until every result has come out
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_nodes(input logic [NC_W-1:0] val);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    active_n = (val == 0) ? 1 : ((val > MAXN) ? MAXN : int'(val));
  endtask

  function automatic logic [15:0] rand_weight();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 16'($urandom_range(20, 1));
    else if (pick < 50) return 16'($urandom_range(32767, 1));
    else if (pick < 55) return 16'h7fff;
    else if (pick < 85) return 16'(32'd0 - $urandom_range(32768, 0));
    else return 16'($urandom);
  endfunction

  task automatic random_burst(input int count);
    logic [3:0] src;
    int         i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(99) < 80) src = 4'($urandom_range(active_n - 1, 0));
        else src = 4'($urandom);
        send_item(CMD_SEARCH, 4'($urandom), 4'($urandom), 16'($urandom), src);
      end else begin
        send_item(CMD_LOAD, 4'($urandom), 4'($urandom), rand_weight(), 4'($urandom));
      end
    end
  endtask

  initial begin
    int f;
    int t;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single vertex, self loop and a source past the node count
    set_nodes(5'd1);
    send_item(CMD_LOAD, 4'd0, 4'd0, 16'd7, 4'hf);
    send_item(CMD_SEARCH, 4'hf, 4'hf, 16'hffff, 4'd0);
    send_item(CMD_SEARCH, 4'h0, 4'h0, 16'h0000, 4'd15);
    // zero node count acts as one
    set_nodes(5'd0);
    send_item(CMD_SEARCH, 4'h5, 4'ha, 16'h8000, 4'd0);
    send_item(CMD_SEARCH, 4'ha, 4'h5, 16'h7fff, 4'd1);
    // two vertices: weight extremes, zero and negative are no edge
    set_nodes(5'd2);
    send_item(CMD_LOAD, 4'd0, 4'd1, 16'h8000, 4'h0);
    send_item(CMD_LOAD, 4'd1, 4'd0, 16'h7fff, 4'hf);
    send_item(CMD_LOAD, 4'd1, 4'd1, 16'h0000, 4'h3);
    send_item(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd0);
    send_item(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd1);
    send_item(CMD_LOAD, 4'd0, 4'd1, 16'h0001, 4'hc);
    send_item(CMD_SEARCH, 4'd3, 4'd9, 16'h1234, 4'd0);
    send_item(CMD_LOAD, 4'd0, 4'd1, 16'h0000, 4'h0);
    send_item(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd0);
    send_item(CMD_SEARCH, 4'd0, 4'd0, 16'h0000, 4'd3);

    // every matrix entry written before full-size searches
    set_nodes(5'd16);
    for (f = 0; f < MAXN; f++) begin
      for (t = 0; t < MAXN; t++) begin
        send_item(CMD_LOAD, 4'(f), 4'(t), rand_weight(), 4'($urandom));
      end
    end
    random_burst(20);
    set_nodes(5'd31);
    random_burst(20);

    tx_idle_pct = 47;
    rx_idle_pct = 8;
    set_nodes(5'($urandom_range(15, 3)));
    random_burst(20);
    set_nodes(5'd16);
    random_burst(20);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_nodes(5'($urandom_range(16, 1)));
    random_burst(20);
    set_nodes(5'd16);
    random_burst(20);

    wait_quiet();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/spd_pkg.sv
rtl/core/spd_weight_ram.sv
rtl/core/spd_alu.sv
rtl/core/shortest_path_matrix_dijkstra.sv
test/spd_route_checker.sv
test/shortest_path_matrix_dijkstra_tb.sv
